// ===== hdl/rtt_pkg.sv =====
package rtt_pkg;

	localparam int CMD_W   = 3;
	localparam int TAG_W   = 32;
	localparam int LEN_W   = 12;
	localparam int SEQ_W   = 7;
	localparam int STEP_W  = 5;
	localparam int RECV_W  = 16;
	localparam int KIND_W  = 3;
	localparam int STAT_W  = 3;
	localparam int DATA_W  = 32;
	localparam int PADDR_W = 3;

	localparam int DEPTH_DEF = 64;

	localparam logic [STEP_W-1:0] CATCHUP_RST = 5'd3;
	localparam logic [LEN_W-1:0]  MAX_LEN_RST = 12'd512;

	// register select is paddr[2]
	localparam logic REG_CATCHUP = 1'b0;
	localparam logic REG_MAX_LEN = 1'b1;

	localparam logic [CMD_W-1:0] CMD_SEND   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_UNREL  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_RESEND = 3'd2;
	localparam logic [CMD_W-1:0] CMD_SCHED  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_HB     = 3'd4;
	localparam logic [CMD_W-1:0] CMD_TICK   = 3'd5;
	localparam logic [CMD_W-1:0] CMD_READ   = 3'd6;
	localparam logic [CMD_W-1:0] CMD_RESET  = 3'd7;

	localparam logic [KIND_W-1:0] KIND_NEW    = 3'd0;
	localparam logic [KIND_W-1:0] KIND_RESEND = 3'd1;
	localparam logic [KIND_W-1:0] KIND_UNREL  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_HELLO  = 3'd3;
	localparam logic [KIND_W-1:0] KIND_STATUS = 3'd4;

	localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
	localparam logic [STAT_W-1:0] STAT_TOO_LONG  = 3'd1;
	localparam logic [STAT_W-1:0] STAT_FULL      = 3'd2;
	localparam logic [STAT_W-1:0] STAT_RANGE     = 3'd3;
	localparam logic [STAT_W-1:0] STAT_BAD_ORDER = 3'd4;

	// one queued command, already classified by the front end
	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [TAG_W-1:0]  tag;
		logic              too_long;
		logic [SEQ_W-1:0]  index;
		logic [SEQ_W-1:0]  range_end;
		logic              always_send;
		logic              recv_small;
		logic [SEQ_W-1:0]  recv_lo;
	} cmd_t;

	typedef struct packed {
		logic              strobe;
		logic [KIND_W-1:0] kind;
		logic [SEQ_W-1:0]  seq;
		logic [TAG_W-1:0]  payload;
		logic [STAT_W-1:0] status;
		logic [SEQ_W-1:0]  cnt;
		logic              last;
	} res_t;

endpackage

// ===== hdl/rtt_front.sv =====
module rtt_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [rtt_pkg::CMD_W-1:0]   command,
	input  logic [rtt_pkg::TAG_W-1:0]   payload_tag,
	input  logic [rtt_pkg::LEN_W-1:0]   payload_length,
	input  logic [rtt_pkg::SEQ_W-1:0]   index,
	input  logic [rtt_pkg::SEQ_W-1:0]   range_end,
	input  logic                        always_send,
	input  logic [rtt_pkg::RECV_W-1:0]  received_count,
	input  logic [rtt_pkg::LEN_W-1:0]   max_length,
	output rtt_pkg::cmd_t               head,
	output logic                        head_valid,
	input  logic                        pop
);
	import rtt_pkg::*;

	cmd_t       ent_q [2];
	cmd_t       ent_in;
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       accept;

	assign busy       = (fill_q == 2'd2);
	assign accept     = start & ~busy;
	assign head       = ent_q[rd_ptr_q];
	assign head_valid = (fill_q != 2'd0);

	always_comb begin
		ent_in.cmd         = command;
		ent_in.tag         = payload_tag;
		ent_in.too_long    = (payload_length > max_length);
		ent_in.index       = index;
		ent_in.range_end   = range_end;
		ent_in.always_send = always_send;
		// only a count below the store size can schedule anything
		ent_in.recv_small  = (received_count[RECV_W-1:SEQ_W] == '0);
		ent_in.recv_lo     = received_count[SEQ_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ent_q[wr_ptr_q] <= ent_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (accept) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({accept, pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

// ===== hdl/rtt_back.sv =====
module rtt_back #(
	parameter int DEPTH = rtt_pkg::DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  rtt_pkg::cmd_t               head,
	input  logic                        head_valid,
	output logic                        pop,
	input  logic [rtt_pkg::STEP_W-1:0]  catchup_step,
	output rtt_pkg::res_t               res
);
	import rtt_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_EXEC  = 3'd1;
	localparam logic [2:0] ST_RDOUT = 3'd2;
	localparam logic [2:0] ST_WALK  = 3'd3;
	localparam logic [2:0] ST_FLUSH = 3'd4;

	logic [2:0]        state_q;
	cmd_t              cur_q;
	logic [SEQ_W-1:0]  count_q;
	logic [SEQ_W-1:0]  pend_q;
	logic [SEQ_W-1:0]  walk_q;
	logic [DEPTH-1:0]  flags_q;
	logic [DEPTH-1:0]  flags_d;
	logic [DEPTH-1:0]  mark_vec;
	logic              hit_s1;
	logic [SEQ_W-1:0]  hit_idx_s1;
	logic [SEQ_W-1:0]  held_idx_q;
	logic [TAG_W-1:0]  held_data_q;
	logic              have_q;
	res_t              res_q;

	logic [TAG_W-1:0]  mem [DEPTH];
	logic [TAG_W-1:0]  rd_data_q;
	logic [AW-1:0]     rd_addr;
	logic              mem_we;

	logic              lk_miss;
	logic [SEQ_W-1:0]  lk_idx;
	logic [SEQ_W-1:0]  lk_dec;
	logic [SEQ_W-1:0]  walk_dec;
	logic [AW-1:0]     walk_addr;
	logic              walk_in;
	logic              walk_hit;
	logic [STAT_W-1:0] sch_status;
	logic              hb_go;
	logic [SEQ_W:0]    hb_sum;
	logic [SEQ_W-1:0]  hb_last;
	logic [SEQ_W-1:0]  hb_first;
	logic [SEQ_W-1:0]  hb_cnt;
	logic              mark_en;
	logic [SEQ_W-1:0]  mark_s;
	logic [SEQ_W-1:0]  mark_e;
	logic              store_full;

	function automatic res_t mk_res(input logic [KIND_W-1:0] kind,
	                                input logic [SEQ_W-1:0] seq,
	                                input logic [TAG_W-1:0] payload,
	                                input logic [STAT_W-1:0] status,
	                                input logic [SEQ_W-1:0] cnt,
	                                input logic last);
		res_t r;
		r.strobe  = 1'b1;
		r.kind    = kind;
		r.seq     = seq;
		r.payload = payload;
		r.status  = status;
		r.cnt     = cnt;
		r.last    = last;
		return r;
	endfunction

	assign res = res_q;
	assign pop = (state_q == ST_IDLE) && head_valid;

	always_comb begin
		// index 0 means the newest entry
		lk_miss    = (cur_q.index > count_q) || (cur_q.index == '0 && count_q == '0);
		lk_idx     = (cur_q.index == '0) ? count_q : cur_q.index;
		lk_dec     = lk_idx - SEQ_W'(1);
		walk_dec   = walk_q - SEQ_W'(1);
		walk_addr  = walk_dec[AW-1:0];
		walk_in    = (walk_q <= count_q);
		walk_hit   = (state_q == ST_WALK) && walk_in && flags_q[walk_addr];
		rd_addr    = (state_q == ST_WALK) ? walk_addr : lk_dec[AW-1:0];
		store_full = (count_q >= SEQ_W'(DEPTH));
		mem_we     = (state_q == ST_EXEC) && (cur_q.cmd == CMD_SEND) &&
		             !cur_q.too_long && !store_full;

		if (cur_q.range_end < cur_q.index) begin
			sch_status = STAT_BAD_ORDER;
		end else if (cur_q.range_end > count_q || cur_q.index == '0) begin
			sch_status = STAT_RANGE;
		end else begin
			sch_status = STAT_OK;
		end

		hb_go    = cur_q.recv_small && (cur_q.recv_lo < count_q);
		hb_sum   = {1'b0, cur_q.recv_lo} + (SEQ_W+1)'(catchup_step);
		hb_last  = (hb_sum > {1'b0, count_q}) ? count_q : hb_sum[SEQ_W-1:0];
		hb_first = cur_q.recv_lo + SEQ_W'(1);
		hb_cnt   = hb_go ? (hb_last - cur_q.recv_lo) : '0;

		mark_en = 1'b0;
		mark_s  = cur_q.index;
		mark_e  = cur_q.range_end;
		if (state_q == ST_EXEC) begin
			if (cur_q.cmd == CMD_SCHED && sch_status == STAT_OK) begin
				mark_en = 1'b1;
			end else if (cur_q.cmd == CMD_HB && hb_go && hb_last >= hb_first) begin
				mark_en = 1'b1;
				mark_s  = hb_first;
				mark_e  = hb_last;
			end
		end

		for (int i = 0; i < DEPTH; i++) begin
			mark_vec[i] = mark_en && (SEQ_W'(i + 1) >= mark_s) && (SEQ_W'(i + 1) <= mark_e);
		end

		flags_d = flags_q | mark_vec;
		if (state_q == ST_EXEC && cur_q.cmd == CMD_RESET) begin
			flags_d = '0;
		end
		if (state_q == ST_WALK && walk_in) begin
			flags_d[walk_addr] = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[count_q[AW-1:0]] <= cur_q.tag;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else begin
			flags_q <= flags_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cur_q       <= '0;
			count_q     <= '0;
			pend_q      <= '0;
			walk_q      <= '0;
			hit_s1      <= 1'b0;
			hit_idx_s1  <= '0;
			held_idx_q  <= '0;
			held_data_q <= '0;
			have_q      <= 1'b0;
			res_q       <= '0;
		end else begin
			res_q.strobe <= 1'b0;
			hit_s1       <= walk_hit;

			// a new hit pushes out the one held before it
			if ((state_q inside {ST_WALK, ST_FLUSH}) && hit_s1) begin
				if (have_q) begin
					res_q <= mk_res(KIND_RESEND, held_idx_q, held_data_q, STAT_OK,
					                count_q, 1'b0);
				end
				held_idx_q  <= hit_idx_s1;
				held_data_q <= rd_data_q;
				have_q      <= 1'b1;
			end

			case (state_q)
				ST_IDLE: begin
					if (head_valid) begin
						cur_q   <= head;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= ST_IDLE;
					case (cur_q.cmd)
						CMD_SEND: begin
							if (cur_q.too_long) begin
								res_q <= mk_res(KIND_STATUS, '0, '0, STAT_TOO_LONG,
								                count_q, 1'b1);
							end else if (store_full) begin
								res_q <= mk_res(KIND_STATUS, '0, '0, STAT_FULL,
								                count_q, 1'b1);
							end else begin
								count_q <= count_q + SEQ_W'(1);
								res_q   <= mk_res(KIND_NEW, count_q + SEQ_W'(1), cur_q.tag,
								                  STAT_OK, count_q + SEQ_W'(1), 1'b1);
							end
						end
						CMD_UNREL: begin
							res_q <= mk_res(KIND_UNREL, '0, cur_q.tag, STAT_OK, count_q, 1'b1);
						end
						CMD_RESEND, CMD_READ: begin
							if (!lk_miss) begin
								hit_idx_s1 <= lk_idx;
								state_q    <= ST_RDOUT;
							end else if (cur_q.cmd == CMD_RESEND && cur_q.always_send) begin
								res_q <= mk_res(KIND_HELLO, '0, '0, STAT_OK, count_q, 1'b1);
							end else begin
								res_q <= mk_res(KIND_STATUS, '0, '0, STAT_RANGE, count_q, 1'b1);
							end
						end
						CMD_SCHED: begin
							if (mark_en && (pend_q == '0 || pend_q > mark_s)) begin
								pend_q <= mark_s;
							end
							res_q <= mk_res(KIND_STATUS, '0, '0, sch_status, count_q, 1'b1);
						end
						CMD_HB: begin
							if (mark_en && (pend_q == '0 || pend_q > mark_s)) begin
								pend_q <= mark_s;
							end
							res_q <= mk_res(KIND_STATUS, '0, '0, STAT_OK, hb_cnt, 1'b1);
						end
						CMD_TICK: begin
							// the walk always ends past the last entry
							if (pend_q != '0) begin
								walk_q  <= pend_q;
								pend_q  <= '0;
								have_q  <= 1'b0;
								state_q <= ST_WALK;
							end
						end
						default: begin
							count_q <= '0;
							pend_q  <= '0;
							res_q   <= mk_res(KIND_STATUS, '0, '0, STAT_OK, '0, 1'b1);
						end
					endcase
				end
				ST_RDOUT: begin
					res_q <= mk_res((cur_q.cmd == CMD_RESEND) ? KIND_RESEND : KIND_STATUS,
					                hit_idx_s1, rd_data_q, STAT_OK, count_q, 1'b1);
					state_q <= ST_IDLE;
				end
				ST_WALK: begin
					if (!walk_in) begin
						state_q <= ST_FLUSH;
					end else begin
						walk_q <= walk_q + SEQ_W'(1);
						if (walk_hit) begin
							hit_idx_s1 <= walk_q;
						end
					end
				end
				ST_FLUSH: begin
					// wait out the last read, then drain the held word as final
					if (!hit_s1) begin
						if (have_q) begin
							res_q <= mk_res(KIND_RESEND, held_idx_q, held_data_q, STAT_OK,
							                count_q, 1'b1);
						end
						have_q  <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== hdl/retransmit_tracker.sv =====
// Sender-side retransmission tracker for a reliable command channel.
// Commands enter on start/busy: a command is taken at a rising edge with start
// high and busy low. A two-word queue sits between the command decode and the
// executing engine, so busy rises only when two commands wait behind one that
// is still running.
// Results leave on result_strobe, one word per cycle, with last_flag marking
// the final word of a command. The receiver cannot stall; every word is taken
// in the cycle it is shown.
// A taken command passes through the queue into the engine's command register;
// its result is registered in the execute state, or for resend and read in a
// read-out state after the registered store read. The queue takes new commands
// while the engine is still running one.
// A tick walks the resend flags one entry per cycle from the lowest pending
// entry to the stored count, then drains through the flush state, giving
// one resend word per flagged entry.
// Registers via APB (pready is tied high): catchup_step at 0x0, max_length at
// 0x4, written by the user only while the block is idle; nothing enforces it.
// Reset clears the stored count, resend flags, pending pointer and queue, and
// loads catchup_step = 3, max_length = 512. The payload store is not cleared.
module retransmit_tracker #(
	parameter int DEPTH = rtt_pkg::DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [rtt_pkg::PADDR_W-1:0]  paddr,
	input  logic [rtt_pkg::DATA_W-1:0]   pwdata,
	output logic [rtt_pkg::DATA_W-1:0]   prdata,
	output logic                         pready,
	input  logic                         start,
	output logic                         busy,
	input  logic [rtt_pkg::CMD_W-1:0]    command,
	input  logic [rtt_pkg::TAG_W-1:0]    payload_tag,
	input  logic [rtt_pkg::LEN_W-1:0]    payload_length,
	input  logic [rtt_pkg::SEQ_W-1:0]    index,
	input  logic [rtt_pkg::SEQ_W-1:0]    range_end,
	input  logic                         always_send,
	input  logic [rtt_pkg::RECV_W-1:0]   received_count,
	output logic                         result_strobe,
	output logic [rtt_pkg::KIND_W-1:0]   kind,
	output logic [rtt_pkg::SEQ_W-1:0]    sequence_res,
	output logic [rtt_pkg::TAG_W-1:0]    payload_out,
	output logic [rtt_pkg::STAT_W-1:0]   status,
	output logic [rtt_pkg::SEQ_W-1:0]    count,
	output logic                         last_flag
);
	import rtt_pkg::*;

	logic [STEP_W-1:0] catchup_q;
	logic [LEN_W-1:0]  max_len_q;
	logic              cfg_wr;
	cmd_t              head;
	logic              head_valid;
	logic              pop;
	res_t              res;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			catchup_q <= CATCHUP_RST;
			max_len_q <= MAX_LEN_RST;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_MAX_LEN) begin
				max_len_q <= pwdata[LEN_W-1:0];
			end else begin
				catchup_q <= pwdata[STEP_W-1:0];
			end
		end
	end

	always_comb begin
		if (paddr[2] == REG_CATCHUP) begin
			prdata = DATA_W'(catchup_q);
		end else begin
			prdata = DATA_W'(max_len_q);
		end
	end

	rtt_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.command        (command),
		.payload_tag    (payload_tag),
		.payload_length (payload_length),
		.index          (index),
		.range_end      (range_end),
		.always_send    (always_send),
		.received_count (received_count),
		.max_length     (max_len_q),
		.head           (head),
		.head_valid     (head_valid),
		.pop            (pop)
	);

	rtt_back #(
		.DEPTH (DEPTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.head_valid   (head_valid),
		.pop          (pop),
		.catchup_step (catchup_q),
		.res          (res)
	);

	assign result_strobe = res.strobe;
	assign kind          = res.kind;
	assign sequence_res  = res.seq;
	assign payload_out   = res.payload;
	assign status        = res.status;
	assign count         = res.cnt;
	assign last_flag     = res.last;

endmodule

// ===== hdl/rtt_checker.sv =====
module rtt_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        result_strobe,
	input  logic [rtt_pkg::KIND_W-1:0]  kind,
	input  logic [rtt_pkg::SEQ_W-1:0]   sequence_res,
	input  logic [rtt_pkg::STAT_W-1:0]  status,
	input  logic [rtt_pkg::SEQ_W-1:0]   count,
	input  logic                        last_flag
);
	import rtt_pkg::*;

	// an error code only ever rides on a status word
	a_status_kind: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && status != STAT_OK |-> kind == KIND_STATUS)
		else $error("error status on a non-status word");

	// a new send carries the entry just stored, which is the new count
	a_new_seq: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && kind == KIND_NEW |-> sequence_res == count && sequence_res != '0)
		else $error("new send sequence does not match stored count");

	a_resend_seq: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && kind == KIND_RESEND |-> sequence_res != '0 && sequence_res <= count)
		else $error("resend of an entry outside the store");

	// only a tick walk gives more than one word per command
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && kind != KIND_RESEND |-> last_flag)
		else $error("single-word result without last flag");

	a_unnumbered: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && (kind == KIND_HELLO || kind == KIND_UNREL) |-> sequence_res == '0)
		else $error("unnumbered word carries a sequence");

endmodule

bind retransmit_tracker rtt_checker u_rtt_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.result_strobe (result_strobe),
	.kind          (kind),
	.sequence_res  (sequence_res),
	.status        (status),
	.count         (count),
	.last_flag     (last_flag)
);

// ===== test/tb_retransmit_tracker.sv =====
module tb_retransmit_tracker;
	timeunit 1ns;
	timeprecision 1ps;

	import rtt_pkg::*;

	localparam int DEPTH       = DEPTH_DEF;
	localparam int QUIET_LIMIT = 1000;
	localparam int SETTLE      = 100;

	typedef struct packed {
		logic [CMD_W-1:0]  op;
		logic [TAG_W-1:0]  tag;
		logic [LEN_W-1:0]  len;
		logic [SEQ_W-1:0]  idx;
		logic [SEQ_W-1:0]  end_idx;
		logic              hello_ok;
		logic [RECV_W-1:0] recv;
	} cmd_word_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [SEQ_W-1:0]  seq;
		logic [TAG_W-1:0]  payload;
		logic [STAT_W-1:0] stat;
		logic [SEQ_W-1:0]  cnt;
		logic              last;
	} res_word_t;

	class resend_scoreboard;
		logic [TAG_W-1:0]  tags[DEPTH];
		bit                marked[DEPTH];
		int unsigned       entries;
		int unsigned       walk_from;
		logic [STEP_W-1:0] catchup;
		logic [LEN_W-1:0]  max_len;
		res_word_t         owed[$];
		int                errors;
		int                words_checked;
		int                cmd_seen[8];
		int                full_hits;
		int                longest_walk;

		function new();
			foreach (tags[i]) begin
				tags[i] = '0;
				marked[i] = 1'b0;
			end
			entries = 0;
			walk_from = 0;
			catchup = CATCHUP_RST;
			max_len = MAX_LEN_RST;
			errors = 0;
			words_checked = 0;
			full_hits = 0;
			longest_walk = 0;
			foreach (cmd_seen[i]) cmd_seen[i] = 0;
		endfunction

		function void set_reg(logic sel, logic [DATA_W-1:0] v);
			if (sel == REG_CATCHUP) catchup = v[STEP_W-1:0];
			else max_len = v[LEN_W-1:0];
		endfunction

		function logic [DATA_W-1:0] reg_value(logic sel);
			if (sel == REG_CATCHUP) return DATA_W'(catchup);
			return DATA_W'(max_len);
		endfunction

		function int pending_words();
			return owed.size();
		endfunction

		function void queue_word(logic [KIND_W-1:0] k, int unsigned sq, logic [TAG_W-1:0] p,
				logic [STAT_W-1:0] st, int unsigned n);
			res_word_t w;
			w.kind = k;
			w.seq = sq[SEQ_W-1:0];
			w.payload = p;
			w.stat = st;
			w.cnt = n[SEQ_W-1:0];
			w.last = 1'b0;
			owed.push_back(w);
		endfunction

		// 0 when the entry is missing
		function int unsigned find_entry(int unsigned i);
			if (i > entries) return 0;
			if (i == 0) return entries;
			return i;
		endfunction

		function logic [STAT_W-1:0] mark_range(int unsigned s, int unsigned e);
			int unsigned i;
			if (e < s) return STAT_BAD_ORDER;
			if (e > entries || s == 0) return STAT_RANGE;
			if (walk_from == 0 || walk_from > s) walk_from = s;
			for (i = s; i <= e && i <= DEPTH; i++) marked[i-1] = 1'b1;
			return STAT_OK;
		endfunction

		function void note_command(cmd_word_t c);
			int unsigned e, i, rc, lim;
			int n0;
			n0 = owed.size();
			cmd_seen[c.op]++;
			case (c.op)
				CMD_SEND: begin
					if (c.len > max_len) begin
						queue_word(KIND_STATUS, 0, '0, STAT_TOO_LONG, entries);
					end else if (entries >= DEPTH) begin
						full_hits++;
						queue_word(KIND_STATUS, 0, '0, STAT_FULL, entries);
					end else begin
						tags[entries] = c.tag;
						entries++;
						queue_word(KIND_NEW, entries, c.tag, STAT_OK, entries);
					end
				end
				CMD_UNREL: queue_word(KIND_UNREL, 0, c.tag, STAT_OK, entries);
				CMD_RESEND: begin
					e = find_entry(c.idx);
					if (e != 0) queue_word(KIND_RESEND, e, tags[e-1], STAT_OK, entries);
					else if (c.hello_ok) queue_word(KIND_HELLO, 0, '0, STAT_OK, entries);
					else queue_word(KIND_STATUS, 0, '0, STAT_RANGE, entries);
				end
				CMD_SCHED: queue_word(KIND_STATUS, 0, '0, mark_range(c.idx, c.end_idx), entries);
				CMD_HB: begin
					rc = c.recv;
					if (rc < entries) begin
						lim = rc + catchup;
						if (lim > entries) lim = entries;
						void'(mark_range(rc + 1, lim));
						queue_word(KIND_STATUS, 0, '0, STAT_OK, lim - rc);
					end else begin
						queue_word(KIND_STATUS, 0, '0, STAT_OK, 0);
					end
				end
				CMD_TICK: begin
					if (walk_from != 0) begin
						for (i = walk_from; i <= entries && i <= DEPTH; i++) begin
							if (marked[i-1]) begin
								queue_word(KIND_RESEND, i, tags[i-1], STAT_OK, entries);
								marked[i-1] = 1'b0;
							end
							if (walk_from == i) walk_from++;
						end
						if (walk_from > entries) walk_from = 0;
					end
					if (owed.size() - n0 > longest_walk) longest_walk = owed.size() - n0;
				end
				CMD_READ: begin
					e = find_entry(c.idx);
					if (e != 0) queue_word(KIND_STATUS, e, tags[e-1], STAT_OK, entries);
					else queue_word(KIND_STATUS, 0, '0, STAT_RANGE, entries);
				end
				default: begin
					entries = 0;
					walk_from = 0;
					foreach (marked[k]) marked[k] = 1'b0;
					queue_word(KIND_STATUS, 0, '0, STAT_OK, 0);
				end
			endcase
			if (owed.size() > n0) owed[owed.size()-1].last = 1'b1;
		endfunction

		task report_mismatch(string msg);
			errors++;
			if (errors <= 40) $display("MISMATCH at %0t: %s", $realtime, msg);
		endtask

		task check_word(res_word_t got);
			res_word_t want;
			if (owed.size() == 0) begin
				report_mismatch($sformatf("word with nothing due: kind %0d seq %0d payload %h",
					got.kind, got.seq, got.payload));
				return;
			end
			want = owed.pop_front();
			words_checked++;
			if (got.kind !== want.kind)
				report_mismatch($sformatf("word %0d kind %0d, want %0d",
					words_checked, got.kind, want.kind));
			if (got.seq !== want.seq)
				report_mismatch($sformatf("word %0d sequence %0d, want %0d",
					words_checked, got.seq, want.seq));
			if (got.payload !== want.payload)
				report_mismatch($sformatf("word %0d payload %h, want %h",
					words_checked, got.payload, want.payload));
			if (got.stat !== want.stat)
				report_mismatch($sformatf("word %0d status %0d, want %0d",
					words_checked, got.stat, want.stat));
			if (got.cnt !== want.cnt)
				report_mismatch($sformatf("word %0d count %0d, want %0d",
					words_checked, got.cnt, want.cnt));
			if (got.last !== want.last)
				report_mismatch($sformatf("word %0d last_flag %b, want %b",
					words_checked, got.last, want.last));
		endtask
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [PADDR_W-1:0]  paddr = '0;
	logic [DATA_W-1:0]   pwdata = '0;
	logic [DATA_W-1:0]   prdata;
	logic                pready;
	logic                start = 1'b0;
	logic                busy;
	logic [CMD_W-1:0]    command = CMD_TICK;
	logic [TAG_W-1:0]    payload_tag = '0;
	logic [LEN_W-1:0]    payload_length = '0;
	logic [SEQ_W-1:0]    index = '0;
	logic [SEQ_W-1:0]    range_end = '0;
	logic                always_send = 1'b0;
	logic [RECV_W-1:0]   received_count = '0;
	logic                result_strobe;
	logic [KIND_W-1:0]   kind;
	logic [SEQ_W-1:0]    sequence_res;
	logic [TAG_W-1:0]    payload_out;
	logic [STAT_W-1:0]   status;
	logic [SEQ_W-1:0]    count;
	logic                last_flag;

	resend_scoreboard sb = new();
	int quiet_cycles = 0;

	retransmit_tracker u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.start          (start),
		.busy           (busy),
		.command        (command),
		.payload_tag    (payload_tag),
		.payload_length (payload_length),
		.index          (index),
		.range_end      (range_end),
		.always_send    (always_send),
		.received_count (received_count),
		.result_strobe  (result_strobe),
		.kind           (kind),
		.sequence_res   (sequence_res),
		.payload_out    (payload_out),
		.status         (status),
		.count          (count),
		.last_flag      (last_flag)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		res_word_t got;
		if (arst_n && result_strobe) begin
			got.kind = kind;
			got.seq = sequence_res;
			got.payload = payload_out;
			got.stat = status;
			got.cnt = count;
			got.last = last_flag;
			sb.check_word(got);
		end
	end

	// end the run when nothing moves for too long
	always @(posedge clk) begin
		if ((start && !busy) || result_strobe || (psel && penable)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("retransmit_tracker test failed");
			$finish;
		end
	end

	function automatic cmd_word_t mk(logic [CMD_W-1:0] op, logic [TAG_W-1:0] tag,
			logic [LEN_W-1:0] len, logic [SEQ_W-1:0] idx, logic [SEQ_W-1:0] eidx,
			logic hello, logic [RECV_W-1:0] recv);
		cmd_word_t c;
		c.op = op;
		c.tag = tag;
		c.len = len;
		c.idx = idx;
		c.end_idx = eidx;
		c.hello_ok = hello;
		c.recv = recv;
		return c;
	endfunction

	// mostly well-formed commands against the current store, some pure noise
	function automatic cmd_word_t make_cmd(int send_pct, bit allow_reset);
		cmd_word_t c;
		int unsigned n, r, s;
		n = sb.entries;
		c = mk(CMD_TICK, $urandom, LEN_W'($urandom), SEQ_W'($urandom), SEQ_W'($urandom),
			1'($urandom), RECV_W'($urandom));
		if ($urandom_range(0, 9) == 0) begin
			c.op = CMD_W'($urandom_range(0, 7));
		end else begin
			r = $urandom_range(0, 99);
			if (r < send_pct) begin
				c.op = CMD_SEND;
				if ($urandom_range(0, 6) != 0) c.len = LEN_W'($urandom_range(0, sb.max_len));
			end else begin
				r = $urandom_range(0, 99);
				if (r < 8) begin
					c.op = CMD_UNREL;
				end else if (r < 24) begin
					c.op = CMD_RESEND;
					if ($urandom_range(0, 3) != 0) c.idx = SEQ_W'($urandom_range(0, n));
				end else if (r < 40) begin
					c.op = CMD_SCHED;
					if (n > 0 && $urandom_range(0, 3) != 0) begin
						s = $urandom_range(1, n);
						c.idx = SEQ_W'(s);
						c.end_idx = SEQ_W'($urandom_range(s, n));
					end
				end else if (r < 56) begin
					c.op = CMD_HB;
					if ($urandom_range(0, 3) != 0) c.recv = RECV_W'($urandom_range(0, n));
				end else if (r < 76) begin
					c.op = CMD_TICK;
				end else if (r < 92) begin
					c.op = CMD_READ;
					if ($urandom_range(0, 3) != 0) c.idx = SEQ_W'($urandom_range(0, n));
				end else begin
					c.op = CMD_RESET;
				end
			end
		end
		if (c.op == CMD_RESET && !allow_reset) c.op = CMD_TICK;
		return c;
	endfunction

	// start stays high across back-to-back words
	task automatic issue(cmd_word_t c);
		start <= 1'b1;
		command <= c.op;
		payload_tag <= c.tag;
		payload_length <= c.len;
		index <= c.idx;
		range_end <= c.end_idx;
		always_send <= c.hello_ok;
		received_count <= c.recv;
		do @(posedge clk); while (busy);
		sb.note_command(c);
	endtask

	task automatic idle_burst(int n);
		start <= 1'b0;
		command <= CMD_W'($urandom);
		payload_tag <= $urandom;
		index <= SEQ_W'($urandom);
		repeat (n) @(posedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (sb.pending_words() != 0);
	endtask

	task automatic write_reg(logic sel, logic [DATA_W-1:0] value);
		logic [DATA_W-1:0] junk;
		junk = $urandom;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {sel, 2'b00};
		// upper bits beyond the register are ignored
		if (sel == REG_CATCHUP) pwdata <= {junk[DATA_W-1:STEP_W], value[STEP_W-1:0]};
		else pwdata <= {junk[DATA_W-1:LEN_W], value[LEN_W-1:0]};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_reg(sel, value);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic read_reg(logic sel);
		logic [DATA_W-1:0] got;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {sel, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		got = prdata;
		if (got !== sb.reg_value(sel))
			sb.report_mismatch($sformatf("register %0d reads %h, want %h",
				sel, got, sb.reg_value(sel)));
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// change settings only with the engine quiet; an empty tick leaves no word behind
	task automatic reconfigure(logic [STEP_W-1:0] step, logic [LEN_W-1:0] maxl);
		drain();
		repeat (SETTLE) @(posedge clk);
		write_reg(REG_CATCHUP, DATA_W'(step));
		write_reg(REG_MAX_LEN, DATA_W'(maxl));
		read_reg(REG_CATCHUP);
		read_reg(REG_MAX_LEN);
	endtask

	task automatic run_random(int n, int send_pct, bit allow_reset, int calm_tail);
		for (int k = 0; k < n; k++) begin
			if (k < n - calm_tail && $urandom_range(0, 3) == 0)
				idle_burst($urandom_range(1, 14));
			issue(make_cmd(send_pct, allow_reset));
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty store, reset settings (catchup 3, max length 512)
		issue(mk(CMD_READ,   '0, '0, 0, 0, 1'b0, 0));
		issue(mk(CMD_RESEND, '0, '0, 0, 0, 1'b0, 0));
		issue(mk(CMD_RESEND, '0, '0, 5, 0, 1'b1, 0));
		issue(mk(CMD_TICK,   '0, '0, 0, 0, 1'b0, 0));
		issue(mk(CMD_HB,     '0, '0, 0, 0, 1'b0, 0));
		issue(mk(CMD_SCHED,  '0, '0, 1, 1, 1'b0, 0));
		issue(mk(CMD_SEND,   32'hFFFF_FFFF, 12'd512, 0, 0, 1'b0, 0));
		issue(mk(CMD_SEND,   32'h0, 12'd513, 0, 0, 1'b0, 0));
		issue(mk(CMD_SEND,   32'h1234_5678, 12'd4095, 0, 0, 1'b0, 0));
		issue(mk(CMD_SEND,   32'hA5A5_A5A5, 12'd0, 0, 0, 1'b0, 0));
		issue(mk(CMD_SEND,   32'h5A5A_5A5A, 12'd1, 0, 0, 1'b0, 0));
		issue(mk(CMD_UNREL,  32'hDEAD_BEEF, 12'd4095, 127, 127, 1'b1, 16'hFFFF));
		issue(mk(CMD_RESEND, '0, '0, 0, 0, 1'b0, 0));
		issue(mk(CMD_RESEND, '0, '0, 1, 0, 1'b1, 0));
		issue(mk(CMD_READ,   '0, '0, 3, 0, 1'b0, 0));
		issue(mk(CMD_READ,   '0, '0, 127, 0, 1'b0, 0));
		issue(mk(CMD_SCHED,  '0, '0, 3, 2, 1'b0, 0));
		issue(mk(CMD_SCHED,  '0, '0, 0, 2, 1'b0, 0));
		issue(mk(CMD_SCHED,  '0, '0, 2, 127, 1'b0, 0));
		issue(mk(CMD_SCHED,  '0, '0, 2, 3, 1'b0, 0));
		issue(mk(CMD_TICK,   '0, '0, 0, 0, 1'b0, 0));
		issue(mk(CMD_HB,     '0, '0, 0, 0, 1'b0, 0));
		issue(mk(CMD_HB,     '0, '0, 0, 0, 1'b0, 16'hFFFF));
		issue(mk(CMD_TICK,   '0, '0, 0, 0, 1'b0, 0));
		issue(mk(CMD_RESET,  '0, '0, 0, 0, 1'b0, 0));
		issue(mk(CMD_READ,   '0, '0, 0, 0, 1'b0, 0));

		// send-heavy with no resets so the store fills and overflows
		reconfigure(5'd1, 12'd4095);
		run_random(110, 70, 1'b0, 0);

		reconfigure(5'd16, 12'd1);
		run_random(100, 45, 1'b1, 0);

		reconfigure(5'd0, 12'd0);
		run_random(60, 45, 1'b1, 0);

		reconfigure(5'd31, LEN_W'($urandom_range(1, 4095)));
		run_random(140, 45, 1'b1, 80);

		drain();
		repeat (SETTLE) @(posedge clk);

		$display("covered %0d commands: %0d send, %0d unreliable, %0d resend, %0d schedule,",
			sb.cmd_seen.sum(), sb.cmd_seen[CMD_SEND], sb.cmd_seen[CMD_UNREL],
			sb.cmd_seen[CMD_RESEND], sb.cmd_seen[CMD_SCHED]);
		$display("  %0d heartbeat, %0d tick, %0d read, %0d reset; %0d words, %0d full, walk %0d",
			sb.cmd_seen[CMD_HB], sb.cmd_seen[CMD_TICK], sb.cmd_seen[CMD_READ],
			sb.cmd_seen[CMD_RESET], sb.words_checked, sb.full_hits, sb.longest_walk);
		if (sb.errors == 0) begin
			$display("retransmit_tracker test passed");
		end else begin
			$display("retransmit_tracker test failed");
		end
		$finish;
	end

endmodule
